// ===== rtl/core/msim_pkg.sv =====
// msim_pkg: shared types, constants and key-schedule helpers for the
// masked Simon 64/128 encryption unit. No dependencies.
`default_nettype none

package msim_pkg;

    localparam int unsigned WORD_W        = 32;
    localparam int unsigned KEY_WORDS     = 4;
    localparam int unsigned CFG_IDX_W     = 2;
    localparam int unsigned ROUNDS_DEFAULT = 44;

    // z sequence for Simon 64/128, bit j of the schedule sits at Z_TOP - j
    localparam logic [63:0] Z_SEQ    = 64'h36EB19781229CD0F;
    localparam int unsigned Z_TOP    = 61;
    localparam logic [WORD_W-1:0] KEY_CONST = 32'h0000_0003;

    typedef enum logic {
        OP_START = 1'b0,
        OP_ROUND = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_WORD_0 = 2'd0,
        CFG_KEY_WORD_1 = 2'd1,
        CFG_KEY_WORD_2 = 2'd2,
        CFG_KEY_WORD_3 = 2'd3
    } t_cfg_idx;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] t_key_win;

    // value shares and mask shares of both halves
    typedef struct packed {
        t_word left;
        t_word right;
        t_word left_mask;
        t_word right_mask;
    } t_shares;

    // schedule bit for round j, index clamped at the end of the sequence
    function automatic logic z_bit(input logic [5:0] j);
        logic [5:0] jc;
        jc = (j > 6'(Z_TOP)) ? 6'(Z_TOP) : j;
        return Z_SEQ[6'(Z_TOP) - jc];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/msim_req_if.sv =====
// msim_req_if: request channel of the masked Simon unit (valid/ready + payload).
// Depends on msim_pkg.
`default_nettype none

interface msim_req_if
    import msim_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  operation;
    t_word plaintext_high;
    t_word plaintext_low;
    t_word mask_left;
    t_word mask_right;
    t_word and_mask;

    modport source (
        output valid, operation, plaintext_high, plaintext_low,
               mask_left, mask_right, and_mask,
        input  ready
    );
    modport sink (
        input  valid, operation, plaintext_high, plaintext_low,
               mask_left, mask_right, and_mask,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/msim_rsp_if.sv =====
// msim_rsp_if: ciphertext channel of the masked Simon unit (valid/ready + payload).
// Depends on msim_pkg.
`default_nettype none

interface msim_rsp_if
    import msim_pkg::*;
();
    logic  valid;
    logic  ready;
    t_word ciphertext_high;
    t_word ciphertext_low;

    modport source (
        output valid, ciphertext_high, ciphertext_low,
        input  ready
    );
    modport sink (
        input  valid, ciphertext_high, ciphertext_low,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/msim_round.sv =====
// msim_round: one first-order masked Simon round and one key-schedule step.
// Combinational; depends on msim_pkg.
`default_nettype none

module msim_round
    import msim_pkg::*;
(
    input  t_shares    i_cur,
    input  t_key_win   i_kwin,
    input  logic [5:0] i_round,
    input  t_word      i_and_mask,
    output t_shares    o_nxt,
    output t_word      o_new_key
);

    t_word x, mx, a, ma, b, mb, f, tmp;

    always_comb begin
        x  = i_cur.left;
        mx = i_cur.left_mask;
        a  = {x[30:0], x[31]};
        ma = {mx[30:0], mx[31]};
        b  = {x[23:0], x[31:24]};
        mb = {mx[23:0], mx[31:24]};
        // masked AND: result carries i_and_mask as its mask
        f  = (a & b) ^ i_and_mask ^ (a & mb) ^ (b & ma) ^ (ma & mb);

        o_nxt.left       = i_cur.right ^ f ^ {x[29:0], x[31:30]} ^ i_kwin[0];
        o_nxt.left_mask  = i_cur.right_mask ^ i_and_mask ^ {mx[29:0], mx[31:30]};
        o_nxt.right      = x;
        o_nxt.right_mask = mx;

        tmp = {i_kwin[3][2:0], i_kwin[3][31:3]} ^ i_kwin[1];
        tmp = tmp ^ {tmp[0], tmp[31:1]};
        o_new_key = ~i_kwin[0] ^ tmp ^ {31'd0, z_bit(i_round)} ^ KEY_CONST;
    end

endmodule

`default_nettype wire

// ===== rtl/core/masked_simon64_128_encrypt_unit.sv =====
// masked_simon64_128_encrypt_unit: first-order masked Simon 64/128, one round per request.
// Depends on msim_pkg, msim_req_if, msim_rsp_if, msim_round.
// Timing: a start request loads the state registers; the last round request shows
// its ciphertext on o_rsp the cycle after it is accepted. Throughput: one request
// per cycle (one round per clock in msim_round), so a block takes ROUNDS+1 requests;
// requests wait only while a final round is due and the previous ciphertext is unread.
// Reset (i_rst_n low, synchronous): key words cleared, no block active, o_rsp idle.
`default_nettype none

module masked_simon64_128_encrypt_unit
    import msim_pkg::*;
#(
    parameter int unsigned ROUNDS = ROUNDS_DEFAULT
)(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    msim_req_if.sink                  i_req,
    msim_rsp_if.source                o_rsp,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [WORD_W-1:0]    i_cfg_data
);

    localparam int unsigned CNT_W = $clog2(ROUNDS + 1);

    // key registers, read only when a start request loads the window
    t_key_win r_key;

    // block state: shares, round-key window, round counter
    t_shares    r_sh, n_sh;
    t_key_win   r_kwin, n_kwin;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic       r_active, n_active;

    // output register
    logic  r_out_vld, n_out_vld;
    t_word r_ct_hi, r_ct_lo;

    t_shares rnd_nxt;
    t_word   rnd_key;
    logic    acc, acc_start, acc_round, last_round, out_take;

    msim_round u_round (
        .i_cur      (r_sh),
        .i_kwin     (r_kwin),
        .i_round    (6'(r_cnt)),
        .i_and_mask (i_req.and_mask),
        .o_nxt      (rnd_nxt),
        .o_new_key  (rnd_key)
    );

    assign last_round = r_active && (r_cnt == CNT_W'(ROUNDS - 1));
    assign out_take   = r_out_vld && o_rsp.ready;

    // Hold requests off only when the next round could finish a block while the
    // previous ciphertext is still waiting.
    assign i_req.ready = !(last_round && r_out_vld && !o_rsp.ready);

    assign acc       = i_req.valid && i_req.ready;
    assign acc_start = acc && (t_op'(i_req.operation) == OP_START);
    assign acc_round = acc && (t_op'(i_req.operation) == OP_ROUND) && r_active;

    always_comb begin
        n_sh      = r_sh;
        n_kwin    = r_kwin;
        n_cnt     = r_cnt;
        n_active  = r_active;
        n_out_vld = r_out_vld && !out_take;
        if (acc_start) begin
            n_sh.left       = i_req.plaintext_high ^ i_req.mask_left;
            n_sh.right      = i_req.plaintext_low ^ i_req.mask_right;
            n_sh.left_mask  = i_req.mask_left;
            n_sh.right_mask = i_req.mask_right;
            n_kwin          = r_key;
            n_cnt           = '0;
            n_active        = 1'b1;
        end else if (acc_round) begin
            n_sh   = rnd_nxt;
            n_kwin = {rnd_key, r_kwin[3], r_kwin[2], r_kwin[1]};
            n_cnt  = r_cnt + CNT_W'(1);
            if (last_round) begin
                n_active  = 1'b0;
                n_out_vld = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key     <= '0;
            r_cnt     <= '0;
            r_active  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_KEY_WORD_0: r_key[0] <= i_cfg_data;
                    CFG_KEY_WORD_1: r_key[1] <= i_cfg_data;
                    CFG_KEY_WORD_2: r_key[2] <= i_cfg_data;
                    CFG_KEY_WORD_3: r_key[3] <= i_cfg_data;
                    default: ;
                endcase
            end
            r_cnt     <= n_cnt;
            r_active  <= n_active;
            r_out_vld <= n_out_vld;
        end
    end

    // payload: shares, window and ciphertext need no reset
    always_ff @(posedge i_clk) begin
        r_sh   <= n_sh;
        r_kwin <= n_kwin;
        if (acc_round && last_round) begin
            r_ct_hi <= rnd_nxt.left ^ rnd_nxt.left_mask;
            r_ct_lo <= rnd_nxt.right ^ rnd_nxt.right_mask;
        end
    end

    assign o_rsp.valid           = r_out_vld;
    assign o_rsp.ciphertext_high = r_ct_hi;
    assign o_rsp.ciphertext_low  = r_ct_lo;

    // a ciphertext appears only right after the final round of a block
    a_out_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(acc_round && last_round))
        else $error("ciphertext without final round");

    // a start always opens a fresh block at round zero
    a_start_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_start |=> (r_active && r_cnt == '0))
        else $error("start did not open a block");

    // counter stays inside the round range while a block runs
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_cnt < CNT_W'(ROUNDS)))
        else $error("round counter out of range");

    // a pending ciphertext is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_rsp.ready) |-> !(acc_round && last_round))
        else $error("ciphertext overwritten");

endmodule

`default_nettype wire

// ===== dv/masked_simon64_128_encrypt_unit_test.sv =====
// Self-checking testbench for masked_simon64_128_encrypt_unit: random and directed
// start/round requests, a bit-exact predictor of the masked Simon 64/128 datapath.
// Depends on msim_pkg, msim_req_if, msim_rsp_if and the unit itself.
`timescale 1ns / 1ps

module masked_simon64_128_encrypt_unit_test;
    import msim_pkg::*;

    localparam int unsigned NUM_ROUNDS = ROUNDS_DEFAULT;

    typedef struct {
        t_op   op;
        t_word pt_hi;
        t_word pt_lo;
        t_word m_l;
        t_word m_r;
        t_word and_m;
    } simon_req_t;

    typedef struct {
        t_word hi;
        t_word lo;
    } cipher_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    t_word i_cfg_data;

    msim_req_if req_if ();
    msim_rsp_if rsp_if ();

    masked_simon64_128_encrypt_unit #(
        .ROUNDS(NUM_ROUNDS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if.sink),
        .o_rsp      (rsp_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Requests waiting for the driver; the head is the one on the bus.
    simon_req_t pending_reqs[$];
    // Ciphertexts the predictor has produced and the unit has not yet returned.
    cipher_t    cipher_q[$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned err_cnt;
    logic        req_hold;

    // Predictor state: key registers, value and mask shares, round-key window.
    t_word      key_reg[4];
    t_word      key_win[4];
    t_word      l_sh;
    t_word      r_sh;
    t_word      l_mask;
    t_word      r_mask;
    logic [5:0] rnd_cnt;
    logic       busy;

    // Stimulus-side view of the block: rounds still owed to the open block.
    int unsigned gen_left;
    int unsigned gen_blocks;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic t_word rol(input t_word w, input int unsigned n);
        return (w << n) | (w >> (WORD_W - n));
    endfunction

    function automatic t_word ror(input t_word w, input int unsigned n);
        return (w >> n) | (w << (WORD_W - n));
    endfunction

    // z-sequence bit for round j; rounds past the sequence reuse its last bit
    function automatic logic sched_bit(input logic [5:0] j);
        int unsigned k;
        k = (j > Z_TOP) ? Z_TOP : j;
        return Z_SEQ[Z_TOP - k];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_cnt++;
    endtask

    // One accepted request: start loads shares and window, round does one masked
    // Simon round plus one key-schedule step; the last round yields the ciphertext.
    task automatic simon_predict(input simon_req_t r);
        t_word x, mx, ax, bx, am, bm, f, tmp, nk;
        if (r.op == OP_START) begin
            l_sh    = r.pt_hi ^ r.m_l;
            r_sh    = r.pt_lo ^ r.m_r;
            l_mask  = r.m_l;
            r_mask  = r.m_r;
            key_win = key_reg;
            rnd_cnt = '0;
            busy    = 1'b1;
        end else if (busy) begin
            x  = l_sh;
            mx = l_mask;
            ax = rol(x, 1);
            bx = rol(x, 8);
            am = rol(mx, 1);
            bm = rol(mx, 8);
            // masked AND of the two rotations, refreshed with this round's mask
            f  = (ax & bx) ^ r.and_m ^ (ax & bm) ^ (bx & am) ^ (am & bm);
            l_sh   = r_sh ^ f ^ rol(x, 2) ^ key_win[0];
            l_mask = r_mask ^ r.and_m ^ rol(mx, 2);
            r_sh   = x;
            r_mask = mx;

            tmp = ror(key_win[3], 3) ^ key_win[1];
            tmp = tmp ^ ror(tmp, 1);
            nk  = ~key_win[0] ^ tmp ^ t_word'(sched_bit(rnd_cnt)) ^ KEY_CONST;
            key_win[0] = key_win[1];
            key_win[1] = key_win[2];
            key_win[2] = key_win[3];
            key_win[3] = nk;

            rnd_cnt = rnd_cnt + 6'd1;
            if (rnd_cnt >= NUM_ROUNDS) begin
                busy = 1'b0;
                cipher_q.push_back('{l_sh ^ l_mask, r_sh ^ r_mask});
            end
        end
    endtask

    // Driver: holds a request until it is taken, idles at random between requests.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_hold) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                req_if.valid          <= 1'b1;
                req_if.operation      <= pending_reqs[0].op;
                req_if.plaintext_high <= pending_reqs[0].pt_hi;
                req_if.plaintext_low  <= pending_reqs[0].pt_lo;
                req_if.mask_left      <= pending_reqs[0].m_l;
                req_if.mask_right     <= pending_reqs[0].m_r;
                req_if.and_mask       <= pending_reqs[0].and_m;
                req_hold              <= 1'b1;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure.
    always @(negedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: request acceptance feeds the predictor, results are checked in order.
    always @(posedge i_clk) begin
        simon_req_t acc;
        cipher_t    exp_c;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            acc = pending_reqs.pop_front();
            simon_predict(acc);
            req_hold <= 1'b0;
        end
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (cipher_q.size() == 0) begin
                report_mismatch($sformatf("unexpected ciphertext %h_%h",
                                          rsp_if.ciphertext_high, rsp_if.ciphertext_low));
            end else begin
                exp_c = cipher_q.pop_front();
                if (rsp_if.ciphertext_high !== exp_c.hi)
                    report_mismatch($sformatf("ciphertext_high got %h want %h",
                                              rsp_if.ciphertext_high, exp_c.hi));
                if (rsp_if.ciphertext_low !== exp_c.lo)
                    report_mismatch($sformatf("ciphertext_low got %h want %h",
                                              rsp_if.ciphertext_low, exp_c.lo));
            end
        end
    end

    task automatic cfg_write(input t_cfg_idx idx, input t_word data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        key_reg[idx] = data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_key(input t_word k0, input t_word k1, input t_word k2, input t_word k3);
        cfg_write(CFG_KEY_WORD_0, k0);
        cfg_write(CFG_KEY_WORD_1, k1);
        cfg_write(CFG_KEY_WORD_2, k2);
        cfg_write(CFG_KEY_WORD_3, k3);
    endtask

    // Queue one request and track the open block on the stimulus side.
    task automatic queue_req(input simon_req_t r);
        pending_reqs.push_back(r);
        if (r.op == OP_START) begin
            gen_left = NUM_ROUNDS;
        end else if (gen_left != 0) begin
            gen_left--;
            if (gen_left == 0)
                gen_blocks++;
        end
    endtask

    task automatic queue_fixed(input t_op op, input t_word hi, input t_word lo,
                               input t_word ml, input t_word mr, input t_word am);
        simon_req_t r;
        r = '{op, hi, lo, ml, mr, am};
        queue_req(r);
    endtask

    // Wait until every request is taken and every ciphertext is back, then let a
    // trailing round with no result settle.
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || cipher_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Random traffic: mostly full blocks, rare restarts mid-block, and stray
    // rounds when no block is open.
    task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                             input int unsigned n_items, input int unsigned n_blocks);
        simon_req_t  r;
        int unsigned items;
        int unsigned blocks0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        items   = 0;
        blocks0 = gen_blocks;
        while (items < n_items || gen_blocks - blocks0 < n_blocks) begin
            r.pt_hi = $urandom;
            r.pt_lo = $urandom;
            r.m_l   = $urandom;
            r.m_r   = $urandom;
            r.and_m = $urandom;
            if (gen_left == 0)
                r.op = ($urandom_range(99) < 80) ? OP_START : OP_ROUND;
            else
                r.op = ($urandom_range(999) < 3) ? OP_START : OP_ROUND;
            // stray rounds are ignored by the unit and do not count
            if (r.op == OP_START || gen_left != 0)
                items++;
            queue_req(r);
        end
        wait_idle();
    endtask

    initial begin
        err_cnt        = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        req_hold       = 1'b0;
        gen_left       = 0;
        gen_blocks     = 0;
        busy           = 1'b0;
        rnd_cnt        = '0;
        l_sh           = '0;
        r_sh           = '0;
        l_mask         = '0;
        r_mask         = '0;
        for (int i = 0; i < 4; i++) begin
            key_reg[i] = '0;
            key_win[i] = '0;
        end
        i_cfg_we              = 1'b0;
        i_cfg_idx             = CFG_KEY_WORD_0;
        i_cfg_data            = '0;
        req_if.valid          = 1'b0;
        req_if.operation      = OP_START;
        req_if.plaintext_high = '0;
        req_if.plaintext_low  = '0;
        req_if.mask_left      = '0;
        req_if.mask_right     = '0;
        req_if.and_mask       = '0;
        rsp_if.ready          = 1'b0;

        i_rst_n = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Standard 64/128 test key.
        load_key(32'h0302_0100, 32'h0b0a_0908, 32'h1312_1110, 32'h1b1a_1918);

        // Directed: rounds with no block open, extreme fields, restarts mid-block.
        queue_fixed(OP_ROUND, '0, '0, '0, '0, '0);
        queue_fixed(OP_ROUND, '1, '1, '1, '1, '1);
        queue_fixed(OP_START, '1, '1, '1, '1, '1);
        queue_fixed(OP_ROUND, '0, '0, '0, '0, '0);
        queue_fixed(OP_ROUND, '1, '1, '1, '1, '1);
        queue_fixed(OP_START, '0, '0, '1, '1, '0);
        queue_fixed(OP_ROUND, '1, '1, '1, '1, 32'h8000_0001);
        queue_fixed(OP_ROUND, '0, '0, '0, '0, 32'h7fff_fffe);
        queue_fixed(OP_ROUND, '1, '1, '1, '1, '1);
        queue_fixed(OP_START, '0, '0, '0, '0, '1);
        queue_fixed(OP_ROUND, '0, '0, '0, '0, '1);
        // Known plaintext, random masks; left open over the next key change.
        queue_fixed(OP_START, 32'h656b_696c, 32'h2064_6e75, $urandom, $urandom, '1);
        queue_fixed(OP_ROUND, $urandom, $urandom, $urandom, $urandom, $urandom);
        queue_fixed(OP_ROUND, $urandom, $urandom, $urandom, $urandom, $urandom);
        wait_idle();

        // Key change with a block in flight: its window must not move.
        load_key('1, '1, '1, '1);
        run_phase(0, 0, 325, 6);

        load_key('0, '0, '0, '0);
        run_phase(61, 0, 325, 6);

        load_key($urandom, $urandom, $urandom, $urandom);
        run_phase(0, 61, 325, 6);

        load_key('1, '0, $urandom, $urandom);
        run_phase(12, 12, 325, 6);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (10) @(negedge i_clk);

        if (err_cnt == 0 && cipher_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/msim_pkg.sv
rtl/core/msim_req_if.sv
rtl/core/msim_rsp_if.sv
rtl/core/msim_round.sv
rtl/core/masked_simon64_128_encrypt_unit.sv
dv/masked_simon64_128_encrypt_unit_test.sv
